### rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg: shared types and constants
// Mode codes, configuration register indexes, fixed widths and thresholds
// of the roundabout steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package rsp_pkg;

  // roundabout mode
  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_RIGHT = 2'd1,
    MODE_LEFT  = 2'd2
  } mode_e;

  // back-end sequencer
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_MUL  = 2'd2,
    BK_SUM  = 2'd3
  } back_state_e;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_LO  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT   = 3'd5;

  // register and field widths
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned GAIN_W     = 12;
  localparam int unsigned LOCK_W     = 16;
  localparam int unsigned ERR_W      = 16;
  localparam int unsigned STEER_W    = 15;
  localparam int unsigned MODE_W     = 2;

  // divider: quotient magnitude is always below 2^15
  localparam int unsigned QUOT_BITS = 15;
  localparam int unsigned CNT_W     = $clog2(QUOT_BITS);

  // pd arithmetic widths
  localparam int unsigned PROD_P_W = GAIN_W + 1 + ERR_W;
  localparam int unsigned PROD_D_W = GAIN_W + 1 + ERR_W + 1;
  localparam int unsigned ACC_W    = PROD_D_W + 1;
  localparam int signed   STEER_MAX = 16383;
  localparam int signed   STEER_MIN = -16384;

  // detection thresholds, compared on raw samples
  localparam int unsigned OTHERS_MAX       = 300;
  localparam int unsigned ENTRY_OTHERS_MIN = 50;
  localparam int unsigned EXIT_LEVEL       = 150;
  localparam int unsigned SUPPRESS_LEVEL   = 30;
  localparam int unsigned SAMPLE_FLOOR     = 5;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // reset values of the configuration registers
  localparam logic                ENABLE_RST     = 1'b1;
  localparam logic [LEVEL_W-1:0]  ENTRY_HI_RST   = 10'd200;
  localparam logic [LEVEL_W-1:0]  ENTRY_LO_RST   = 10'd45;
  localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 12'd400;
  localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 12'd200;
  localparam logic [LOCK_W-1:0]   LOCKOUT_RST    = 16'd400;

endpackage

`default_nettype wire

### rtl/rsp_fifo.sv
// ----------------------------------------------------------------------------
// rsp_fifo: short register queue
// Decouples the classifying front end from the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_fifo #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

### rtl/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front: sample intake and roundabout classification
// Tracks roundabout mode and exit lockout, suppresses and floors the outer
// samples and hands them to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_front
  import rsp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] outer_left_sample_i,
  input  wire logic [SAMPLE_BITS-1:0] inner_left_sample_i,
  input  wire logic [SAMPLE_BITS-1:0] inner_right_sample_i,
  input  wire logic [SAMPLE_BITS-1:0] outer_right_sample_i,
  input  wire logic                   enable_i,
  input  wire logic [LEVEL_W-1:0]     entry_hi_i,
  input  wire logic [LEVEL_W-1:0]     entry_lo_i,
  input  wire logic [LOCK_W-1:0]      lockout_len_i,
  input  wire logic                   queue_full_i,
  output logic                        push_o,
  output logic [SAMPLE_BITS-1:0]      outer_left_o,
  output logic [SAMPLE_BITS-1:0]      outer_right_o,
  output mode_e                       mode_o
);

  // compare width covers both the samples and the 10-bit thresholds
  localparam int unsigned CW = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
  localparam logic [CW-1:0] K_OTHERS = CW'(OTHERS_MAX);
  localparam logic [CW-1:0] K_MIN    = CW'(ENTRY_OTHERS_MIN);
  localparam logic [CW-1:0] K_EXIT   = CW'(EXIT_LEVEL);
  localparam logic [CW-1:0] K_SUPP   = CW'(SUPPRESS_LEVEL);
  localparam logic [SAMPLE_BITS-1:0] K_FLOOR = SAMPLE_BITS'(SAMPLE_FLOOR);

  mode_e             mode_q, mode_d, mode_entry;
  logic [LOCK_W-1:0] lock_q, lock_d;
  logic [CW-1:0]     a, b, c, d, hi, lo;
  logic              accept, active, pattern, exit_hit;
  logic [SAMPLE_BITS-1:0] a_sup, d_sup;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign push_o     = accept;

  assign a  = CW'(outer_left_sample_i);
  assign b  = CW'(inner_left_sample_i);
  assign c  = CW'(inner_right_sample_i);
  assign d  = CW'(outer_right_sample_i);
  assign hi = CW'(entry_hi_i);
  assign lo = CW'(entry_lo_i);

  assign active  = enable_i && (lock_q == '0);
  assign pattern = (b < K_OTHERS) && (c < K_OTHERS) &&
                   (((a > hi) && (d < K_OTHERS)) || ((d > hi) && (a < K_OTHERS)));

  always_comb begin
    mode_entry = mode_q;
    if (active && pattern && (mode_q == MODE_NONE)) begin
      if ((b < lo) && (a > K_MIN) && (c > K_MIN) && (d > K_MIN)) begin
        mode_entry = MODE_LEFT;
      end else if ((c < lo) && (a > K_MIN) && (b > K_MIN) && (d > K_MIN)) begin
        mode_entry = MODE_RIGHT;
      end
    end
  end

  assign exit_hit = active && (mode_entry != MODE_NONE) && (a < K_EXIT) && (d < K_EXIT);

  always_comb begin
    mode_d = exit_hit ? MODE_NONE : mode_entry;
    if (exit_hit) begin
      lock_d = lockout_len_i;
    end else if (lock_q != '0) begin
      lock_d = lock_q - 1'b1;
    end else begin
      lock_d = lock_q;
    end
  end

  // outer suppression on the side opposite a quiet inner coil
  always_comb begin
    a_sup = outer_left_sample_i;
    d_sup = outer_right_sample_i;
    if (active && (mode_d == MODE_RIGHT) && (b < K_SUPP)) begin
      d_sup = '0;
    end else if (active && (mode_d == MODE_LEFT) && (c < K_SUPP)) begin
      a_sup = '0;
    end
  end

  assign outer_left_o  = (a_sup < K_FLOOR) ? K_FLOOR : a_sup;
  assign outer_right_o = (d_sup < K_FLOOR) ? K_FLOOR : d_sup;
  assign mode_o        = mode_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      lock_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      lock_q <= lock_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back: normalized error and pd law
// Bit-serial restoring divide for (a-d)/(a+d) in Q1.15, then the pd products
// and the saturated steering result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rsp_back
  import rsp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = 10,
  parameter int unsigned HISTORY_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  wire logic [SAMPLE_BITS-1:0] q_outer_left_i,
  input  wire logic [SAMPLE_BITS-1:0] q_outer_right_i,
  input  wire mode_e                  q_mode_i,
  output logic                        pop_o,
  input  wire logic [GAIN_W-1:0]      prop_gain_i,
  input  wire logic [GAIN_W-1:0]      deriv_gain_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [STEER_W-1:0]   steer_drive_o,
  output logic signed [ERR_W-1:0]     direction_error_o,
  output logic [MODE_W-1:0]           roundabout_mode_o
);

  localparam int unsigned S = SAMPLE_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_BITS - 1);

  back_state_e state_q, state_d;

  logic                  neg_q;
  logic [S:0]            rem_q, den_q;
  logic [QUOT_BITS-1:0]  quo_q;
  logic [CNT_W-1:0]      cnt_q;
  mode_e                 mode_q;

  logic signed [ERR_W-1:0]    err_q;
  logic signed [PROD_P_W-1:0] prod_p_q;
  logic signed [PROD_D_W-1:0] prod_d_q;
  logic signed [ERR_W-1:0]    hist_q [HISTORY_DEPTH];

  logic                        out_valid_q;
  logic signed [STEER_W-1:0]   steer_q;
  logic signed [ERR_W-1:0]     err_out_q;
  mode_e                       mode_out_q;

  logic                       out_free, load_out;
  logic [S+1:0]               rem_x2;
  logic                       rem_ge;
  logic signed [ERR_W-1:0]    err_w;
  logic signed [ERR_W:0]      diff_w;
  logic signed [ACC_W-1:0]    acc_w, acc_sh;
  logic signed [STEER_W-1:0]  steer_w;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          pop_o   = 1'b1;
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == CNT_LAST) begin
          state_d = BK_MUL;
        end
      end
      BK_MUL: begin
        state_d = BK_SUM;
      end
      BK_SUM: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // one quotient bit per cycle, remainder always below the divisor
  assign rem_x2 = {rem_q, 1'b0};
  assign rem_ge = (rem_x2 >= {1'b0, den_q});

  assign err_w  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign diff_w = $signed({err_w[ERR_W-1], err_w}) -
                  $signed({hist_q[0][ERR_W-1], hist_q[0]});

  assign acc_w  = ACC_W'(prod_p_q) + ACC_W'(prod_d_q);
  assign acc_sh = acc_w >>> QUOT_BITS;

  always_comb begin
    if (acc_sh > ACC_W'(STEER_MAX)) begin
      steer_w = STEER_W'(STEER_MAX);
    end else if (acc_sh < ACC_W'(STEER_MIN)) begin
      steer_w = STEER_W'(STEER_MIN);
    end else begin
      steer_w = acc_sh[STEER_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == BK_MUL) begin
        for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
          hist_q[i] <= hist_q[i+1];
        end
        hist_q[HISTORY_DEPTH-1] <= err_w;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      neg_q  <= (q_outer_left_i < q_outer_right_i);
      rem_q  <= (q_outer_left_i >= q_outer_right_i) ?
                {1'b0, q_outer_left_i - q_outer_right_i} :
                {1'b0, q_outer_right_i - q_outer_left_i};
      den_q  <= {1'b0, q_outer_left_i} + {1'b0, q_outer_right_i};
      quo_q  <= '0;
      cnt_q  <= '0;
      mode_q <= q_mode_i;
    end
    if (state_q == BK_DIV) begin
      rem_q <= rem_ge ? (S+1)'(rem_x2 - {1'b0, den_q}) : rem_x2[S:0];
      quo_q <= {quo_q[QUOT_BITS-2:0], rem_ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (state_q == BK_MUL) begin
      err_q    <= err_w;
      prod_p_q <= $signed({1'b0, prop_gain_i}) * err_w;
      prod_d_q <= $signed({1'b0, deriv_gain_i}) * diff_w;
    end
    if (load_out) begin
      steer_q    <= steer_w;
      err_out_q  <= err_q;
      mode_out_q <= mode_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign steer_drive_o     = steer_q;
  assign direction_error_o = err_out_q;
  assign roundabout_mode_o = mode_out_q;

endmodule

`default_nettype wire

### rtl/roundabout_steering_pd.sv
// ----------------------------------------------------------------------------
// roundabout_steering_pd: roundabout-aware pd steering from four coils
// Each transaction on the input channel carries four coil samples; each one
// yields exactly one transaction on the output channel with the steering
// drive, the normalized direction error and the roundabout mode.
//
// Channels use valid/stall; a transaction completes on a clock edge with
// valid high and stall low. The front end classifies a sample set in the
// cycle it is taken and places it in a two-entry queue, so in_stall_o rises
// only when that queue is full. The back end runs a one-bit-per-cycle divide,
// then a multiply step and a sum step, and takes the next item from the queue
// only once the last one has reached the output register.
// A stalled result holds in the output register; the back end finishes the
// next item and waits, while the front end keeps filling the queue.
// Reset clears mode, lockout, error history and the queue, and loads the
// register defaults. Configuration writes belong in idle periods, with no
// transaction in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module roundabout_steering_pd
  import rsp_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS   = 10,
  parameter int unsigned HISTORY_DEPTH = 4
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0] outer_left_sample_i,
  input  wire logic [SAMPLE_BITS-1:0] inner_left_sample_i,
  input  wire logic [SAMPLE_BITS-1:0] inner_right_sample_i,
  input  wire logic [SAMPLE_BITS-1:0] outer_right_sample_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [STEER_W-1:0]   steer_drive_o,
  output logic signed [ERR_W-1:0]     direction_error_o,
  output logic [MODE_W-1:0]           roundabout_mode_o
);

  localparam int unsigned QW = 2 * SAMPLE_BITS + MODE_W;

  logic               enable_q;
  logic [LEVEL_W-1:0] entry_hi_q, entry_lo_q;
  logic [GAIN_W-1:0]  prop_gain_q, deriv_gain_q;
  logic [LOCK_W-1:0]  lockout_len_q;

  logic                   push, queue_full, queue_valid, pop;
  logic [SAMPLE_BITS-1:0] front_a, front_d;
  mode_e                  front_mode;
  logic [QW-1:0]          queue_wdata, queue_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= ENABLE_RST;
      entry_hi_q    <= ENTRY_HI_RST;
      entry_lo_q    <= ENTRY_LO_RST;
      prop_gain_q   <= PROP_GAIN_RST;
      deriv_gain_q  <= DERIV_GAIN_RST;
      lockout_len_q <= LOCKOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENABLE:     enable_q      <= cfg_wdata_i[0];
        CFG_ENTRY_HI:   entry_hi_q    <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_ENTRY_LO:   entry_lo_q    <= cfg_wdata_i[LEVEL_W-1:0];
        CFG_PROP_GAIN:  prop_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_DERIV_GAIN: deriv_gain_q  <= cfg_wdata_i[GAIN_W-1:0];
        CFG_LOCKOUT:    lockout_len_q <= cfg_wdata_i[LOCK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rsp_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .outer_left_sample_i  (outer_left_sample_i),
    .inner_left_sample_i  (inner_left_sample_i),
    .inner_right_sample_i (inner_right_sample_i),
    .outer_right_sample_i (outer_right_sample_i),
    .enable_i             (enable_q),
    .entry_hi_i           (entry_hi_q),
    .entry_lo_i           (entry_lo_q),
    .lockout_len_i        (lockout_len_q),
    .queue_full_i         (queue_full),
    .push_o               (push),
    .outer_left_o         (front_a),
    .outer_right_o        (front_d),
    .mode_o               (front_mode)
  );

  assign queue_wdata = {front_a, front_d, front_mode};

  rsp_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (queue_wdata),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .rdata_o (queue_rdata)
  );

  rsp_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_valid_i         (queue_valid),
    .q_outer_left_i    (queue_rdata[QW-1 -: SAMPLE_BITS]),
    .q_outer_right_i   (queue_rdata[MODE_W +: SAMPLE_BITS]),
    .q_mode_i          (mode_e'(queue_rdata[MODE_W-1:0])),
    .pop_o             (pop),
    .prop_gain_i       (prop_gain_q),
    .deriv_gain_i      (deriv_gain_q),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .steer_drive_o     (steer_drive_o),
    .direction_error_o (direction_error_o),
    .roundabout_mode_o (roundabout_mode_o)
  );

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: roundabout steering pd block
// Drives coil sample transactions through the block and checks every unpinned
// result against a cycle-free predictor of mode tracking, lockout, normalized
// error and the pd law. A directed table comes first, then config phases with
// random roundabout passes and noise, random idling on both channels and one
// long result-side hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------

module testbench;
  import rsp_pkg::*;

  localparam int SAMPLE_W        = 10;
  localparam int HIST_DEPTH      = 4;
  localparam int PHASE_COUNT     = 6;
  localparam int PHASE_ITEMS     = 90;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int CYCLE_LIMIT     = 200000;

  typedef struct {
    logic [SAMPLE_W-1:0] outer_l;
    logic [SAMPLE_W-1:0] inner_l;
    logic [SAMPLE_W-1:0] inner_r;
    logic [SAMPLE_W-1:0] outer_r;
  } coil_set_t;

  typedef struct {
    logic signed [STEER_W-1:0] steer;
    logic signed [ERR_W-1:0]   err;
    mode_e                     mode;
  } steer_result_t;

  typedef enum logic {
    ROW_COILS,
    ROW_WRITE
  } row_kind_e;

  typedef struct {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   reg_idx;
    logic [CFG_DATA_W-1:0]  reg_val;
    coil_set_t              coils;
    bit                     pinned;
    steer_result_t          pinned_res;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_index_i;
  logic [CFG_DATA_W-1:0]       cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [SAMPLE_W-1:0]         outer_left_sample_i;
  logic [SAMPLE_W-1:0]         inner_left_sample_i;
  logic [SAMPLE_W-1:0]         inner_right_sample_i;
  logic [SAMPLE_W-1:0]         outer_right_sample_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [STEER_W-1:0]   steer_drive_o;
  logic signed [ERR_W-1:0]     direction_error_o;
  logic [MODE_W-1:0]           roundabout_mode_o;

  // register mirror
  logic                  cfg_enable;
  logic [LEVEL_W-1:0]    cfg_entry_hi;
  logic [LEVEL_W-1:0]    cfg_entry_lo;
  logic [GAIN_W-1:0]     cfg_kp;
  logic [GAIN_W-1:0]     cfg_kd;
  logic [LOCK_W-1:0]     cfg_lockout_len;

  // predicted block state
  mode_e                 track_mode;
  int                    lockout_left;
  int                    err_hist [HIST_DEPTH];

  steer_result_t         pending_results [$];
  steer_result_t         head_result;
  stim_row_t             directed_rows [$];
  logic [CFG_DATA_W-1:0] plan [PHASE_COUNT][CFG_LOCKOUT+1];
  int                    fail_count;
  int                    sent_count;
  int                    cycle_count;
  bit                    quiet_tail;
  bit                    hold_off_pending;

  roundabout_steering_pd dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .outer_left_sample_i  (outer_left_sample_i),
    .inner_left_sample_i  (inner_left_sample_i),
    .inner_right_sample_i (inner_right_sample_i),
    .outer_right_sample_i (outer_right_sample_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .steer_drive_o        (steer_drive_o),
    .direction_error_o    (direction_error_o),
    .roundabout_mode_o    (roundabout_mode_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one item of the predicted block: mode update, suppression, error, pd law
  function automatic steer_result_t steer_predict(input coil_set_t s);
    int a, b, c, d, num, den, err, old;
    longint q, acc;
    bit exited;
    steer_result_t r;
    a = s.outer_l;
    b = s.inner_l;
    c = s.inner_r;
    d = s.outer_r;
    exited = 1'b0;
    if (cfg_enable && lockout_left == 0) begin
      if (track_mode == MODE_NONE &&
          ((a > cfg_entry_hi && b < OTHERS_MAX && c < OTHERS_MAX && d < OTHERS_MAX) ||
           (d > cfg_entry_hi && b < OTHERS_MAX && c < OTHERS_MAX && a < OTHERS_MAX))) begin
        if (b < cfg_entry_lo && a > ENTRY_OTHERS_MIN && c > ENTRY_OTHERS_MIN &&
            d > ENTRY_OTHERS_MIN) begin
          track_mode = MODE_LEFT;
        end else if (c < cfg_entry_lo && a > ENTRY_OTHERS_MIN && b > ENTRY_OTHERS_MIN &&
                     d > ENTRY_OTHERS_MIN) begin
          track_mode = MODE_RIGHT;
        end
      end
      if (track_mode != MODE_NONE) begin
        if (a < EXIT_LEVEL && d < EXIT_LEVEL) begin
          track_mode = MODE_NONE;
          lockout_left = cfg_lockout_len;
          exited = 1'b1;
        end
        if (track_mode == MODE_RIGHT && b < SUPPRESS_LEVEL) begin
          d = 0;
        end else if (track_mode == MODE_LEFT && c < SUPPRESS_LEVEL) begin
          a = 0;
        end
      end
    end
    if (!exited && lockout_left != 0) lockout_left--;

    if (a < SAMPLE_FLOOR) a = SAMPLE_FLOOR;
    if (d < SAMPLE_FLOOR) d = SAMPLE_FLOOR;
    num = a - d;
    den = a + d;
    q = (longint'(num) * 32768) / den;
    if (q > 32767) q = 32767;
    if (q < -32767) q = -32767;
    err = int'(q);

    old = err_hist[0];
    for (int i = 0; i < HIST_DEPTH - 1; i++) err_hist[i] = err_hist[i + 1];
    err_hist[HIST_DEPTH - 1] = err;

    acc = longint'(cfg_kp) * err + longint'(cfg_kd) * (err - old);
    acc = acc >>> 15;
    if (acc > STEER_MAX) acc = STEER_MAX;
    if (acc < STEER_MIN) acc = STEER_MIN;

    r.steer = acc[STEER_W-1:0];
    r.err   = err[ERR_W-1:0];
    r.mode  = track_mode;
    return r;
  endfunction

  function automatic stim_row_t coil_row(input int a, input int b, input int c, input int d);
    stim_row_t row;
    row.kind             = ROW_COILS;
    row.reg_idx          = CFG_ENABLE;
    row.reg_val          = '0;
    row.coils.outer_l    = a[SAMPLE_W-1:0];
    row.coils.inner_l    = b[SAMPLE_W-1:0];
    row.coils.inner_r    = c[SAMPLE_W-1:0];
    row.coils.outer_r    = d[SAMPLE_W-1:0];
    row.pinned           = 1'b0;
    row.pinned_res.steer = '0;
    row.pinned_res.err   = '0;
    row.pinned_res.mode  = MODE_NONE;
    return row;
  endfunction

  function automatic stim_row_t pinned_row(input int a, input int b, input int c, input int d,
                                           input int steer, input int err, input mode_e mode);
    stim_row_t row;
    row = coil_row(a, b, c, d);
    row.pinned           = 1'b1;
    row.pinned_res.steer = steer[STEER_W-1:0];
    row.pinned_res.err   = err[ERR_W-1:0];
    row.pinned_res.mode  = mode;
    return row;
  endfunction

  function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = coil_row(0, 0, 0, 0);
    row.kind    = ROW_WRITE;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  // outer-high / inner-low pattern built around the current thresholds
  function automatic stim_row_t entry_row();
    int hi, lo, hot, warm, lim, low_in, mid_in, a, b, c, d;
    hi = cfg_entry_hi;
    lo = cfg_entry_lo;
    hot = $urandom_range(1023, (hi < 51) ? 51 : ((hi >= 1023) ? 1023 : hi + 1));
    warm = $urandom_range(51, 299);
    lim = (lo > 300) ? 300 : lo;
    low_in = (lim == 0) ? 0 : $urandom_range(0, lim - 1);
    mid_in = $urandom_range(51, 299);
    if ($urandom_range(0, 1) == 1) begin
      a = hot;
      d = warm;
    end else begin
      a = warm;
      d = hot;
    end
    if ($urandom_range(0, 1) == 1) begin
      b = low_in;
      c = mid_in;
    end else begin
      b = mid_in;
      c = low_in;
    end
    // both inner coils low: left entry takes precedence
    if ($urandom_range(0, 9) == 0) b = low_in;
    return coil_row(a, b, c, d);
  endfunction

  function automatic stim_row_t in_mode_row();
    int a, b, c, d;
    a = ($urandom_range(0, 4) != 0) ? $urandom_range(150, 1023) : $urandom_range(0, 1023);
    d = ($urandom_range(0, 4) != 0) ? $urandom_range(150, 1023) : $urandom_range(0, 1023);
    b = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 29) : $urandom_range(30, 1023);
    c = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 29) : $urandom_range(30, 1023);
    return coil_row(a, b, c, d);
  endfunction

  function automatic stim_row_t exit_row();
    return coil_row($urandom_range(0, 149), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 149));
  endfunction

  function automatic stim_row_t noise_row();
    return coil_row($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  task automatic send_coils(input stim_row_t row);
    int gap;
    steer_result_t predicted;
    @(negedge clk_i);
    gap = 0;
    if (!quiet_tail && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i           <= 1'b1;
    outer_left_sample_i  <= row.coils.outer_l;
    inner_left_sample_i  <= row.coils.inner_l;
    inner_right_sample_i <= row.coils.inner_r;
    outer_right_sample_i <= row.coils.outer_r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = steer_predict(row.coils);
    if (row.pinned) begin
      pending_results.push_back(row.pinned_res);
    end else begin
      pending_results.push_back(predicted);
    end
    sent_count++;
  endtask

  // drop valid and let every outstanding result come back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ENABLE:     cfg_enable      = val[0];
      CFG_ENTRY_HI:   cfg_entry_hi    = val[LEVEL_W-1:0];
      CFG_ENTRY_LO:   cfg_entry_lo    = val[LEVEL_W-1:0];
      CFG_PROP_GAIN:  cfg_kp          = val[GAIN_W-1:0];
      CFG_DERIV_GAIN: cfg_kd          = val[GAIN_W-1:0];
      CFG_LOCKOUT:    cfg_lockout_len = val[LOCK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic close_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // entry, a few items inside the roundabout, exit, then some free driving
  task automatic run_roundabout_pass();
    int in_mode_items, after;
    in_mode_items = $urandom_range(1, 6);
    after  = $urandom_range(0, 6);
    send_coils(entry_row());
    repeat (in_mode_items) send_coils(in_mode_row());
    send_coils(exit_row());
    repeat (after) send_coils(noise_row());
  endtask

  // result-side stall: random bursts, calm stretches and one long hold-off
  initial begin : result_stall_gen
    int burst_left, calm_left, held;
    burst_left = 0;
    calm_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        out_stall_i <= 1'b1;
        for (held = 0; held < HOLD_OFF_CYCLES; held++) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (quiet_tail) begin
        out_stall_i <= 1'b0;
      end else if (burst_left != 0) begin
        out_stall_i <= 1'b1;
        burst_left--;
      end else if (calm_left != 0) begin
        out_stall_i <= 1'b0;
        calm_left--;
      end else begin
        burst_left = $urandom_range(1, 11) - 1;
        calm_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 25);
        out_stall_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        fail_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (steer_drive_o !== head_result.steer) begin
          $error("steer_drive: expected %0d, got %0d", head_result.steer, steer_drive_o);
          fail_count++;
        end
        if (direction_error_o !== head_result.err) begin
          $error("direction_error: expected %0d, got %0d", head_result.err,
                 direction_error_o);
          fail_count++;
        end
        if (roundabout_mode_o !== head_result.mode) begin
          $error("roundabout_mode: expected %0d, got %0d", head_result.mode,
                 roundabout_mode_o);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : main_flow
    int stop_at;
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_index_i          = CFG_ENABLE;
    cfg_wdata_i          = '0;
    in_valid_i           = 1'b0;
    outer_left_sample_i  = '0;
    inner_left_sample_i  = '0;
    inner_right_sample_i = '0;
    outer_right_sample_i = '0;
    fail_count           = 0;
    sent_count           = 0;
    quiet_tail           = 1'b0;
    hold_off_pending     = 1'b0;
    cfg_enable           = ENABLE_RST;
    cfg_entry_hi         = ENTRY_HI_RST;
    cfg_entry_lo         = ENTRY_LO_RST;
    cfg_kp               = PROP_GAIN_RST;
    cfg_kd               = DERIV_GAIN_RST;
    cfg_lockout_len      = LOCKOUT_RST;
    track_mode           = MODE_NONE;
    lockout_left         = 0;
    for (int i = 0; i < HIST_DEPTH; i++) err_hist[i] = 0;

    // directed part, register defaults
    directed_rows.push_back(pinned_row(0, 0, 0, 0, 0, 0, MODE_NONE));
    directed_rows.push_back(pinned_row(1023, 1023, 1023, 1023, 0, 0, MODE_NONE));
    directed_rows.push_back(pinned_row(300, 300, 300, 300, 0, 0, MODE_NONE));
    directed_rows.push_back(coil_row(1023, 1023, 1023, 0));
    directed_rows.push_back(coil_row(0, 1023, 1023, 1023));
    // thresholds are strict
    directed_rows.push_back(coil_row(200, 10, 100, 100));
    directed_rows.push_back(coil_row(201, 45, 100, 100));
    directed_rows.push_back(coil_row(201, 44, 51, 51));
    // left mode: outer left zeroed while inner right is low
    directed_rows.push_back(coil_row(600, 100, 29, 100));
    directed_rows.push_back(coil_row(600, 100, 30, 100));
    directed_rows.push_back(coil_row(150, 100, 100, 149));
    directed_rows.push_back(write_row(CFG_LOCKOUT, 16'd3));
    directed_rows.push_back(coil_row(100, 100, 100, 100));
    // entry pattern ignored during lockout
    directed_rows.push_back(coil_row(600, 40, 120, 100));
    directed_rows.push_back(coil_row(0, 0, 0, 0));
    directed_rows.push_back(coil_row(500, 500, 500, 500));
    // right entry from the outer right coil, then outer right zeroed
    directed_rows.push_back(coil_row(100, 120, 30, 700));
    directed_rows.push_back(coil_row(400, 29, 200, 400));
    directed_rows.push_back(coil_row(149, 200, 200, 149));

    // random phases: register settings per phase
    plan[0][CFG_ENABLE] = 16'd1;     plan[0][CFG_ENTRY_HI] = 16'd200;
    plan[0][CFG_ENTRY_LO] = 16'd45;  plan[0][CFG_PROP_GAIN] = 16'd400;
    plan[0][CFG_DERIV_GAIN] = 16'd200; plan[0][CFG_LOCKOUT] = 16'd5;
    plan[1][CFG_ENABLE] = 16'hFFFE;  plan[1][CFG_ENTRY_HI] = 16'd150;
    plan[1][CFG_ENTRY_LO] = 16'd60;  plan[1][CFG_PROP_GAIN] = 16'd4095;
    plan[1][CFG_DERIV_GAIN] = 16'd4095; plan[1][CFG_LOCKOUT] = 16'd2;
    plan[2][CFG_ENABLE] = 16'd1;     plan[2][CFG_ENTRY_HI] = 16'd0;
    plan[2][CFG_ENTRY_LO] = 16'd1023; plan[2][CFG_PROP_GAIN] = 16'd0;
    plan[2][CFG_DERIV_GAIN] = 16'd0; plan[2][CFG_LOCKOUT] = 16'd0;
    plan[3][CFG_ENABLE] = 16'd1;     plan[3][CFG_ENTRY_HI] = 16'hFFFF;
    plan[3][CFG_ENTRY_LO] = 16'hFC00; plan[3][CFG_PROP_GAIN] = 16'hFFFF;
    plan[3][CFG_DERIV_GAIN] = 16'h0000; plan[3][CFG_LOCKOUT] = 16'd1;
    plan[4][CFG_ENABLE] = 16'd1;
    plan[4][CFG_ENTRY_HI] = 16'($urandom_range(100, 400));
    plan[4][CFG_ENTRY_LO] = 16'($urandom_range(20, 120));
    plan[4][CFG_PROP_GAIN] = 16'($urandom_range(0, 65535));
    plan[4][CFG_DERIV_GAIN] = 16'($urandom_range(0, 65535));
    plan[4][CFG_LOCKOUT] = 16'($urandom_range(0, 20));
    plan[5][CFG_ENABLE] = 16'd1;     plan[5][CFG_ENTRY_HI] = 16'd200;
    plan[5][CFG_ENTRY_LO] = 16'd45;  plan[5][CFG_PROP_GAIN] = 16'hF190;
    plan[5][CFG_DERIV_GAIN] = 16'd200; plan[5][CFG_LOCKOUT] = 16'hFFFF;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
        close_writes();
      end else begin
        send_coils(directed_rows[i]);
      end
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == PHASE_COUNT - 1) quiet_tail = 1'b1;
      wait_idle();
      for (int r = CFG_ENABLE; r <= CFG_LOCKOUT; r++) begin
        write_reg(CFG_IDX_W'(r), plan[p][r]);
      end
      // indexes past the register list must be ignored
      if (p == 2) begin
        for (int k = CFG_LOCKOUT + 1; k < 2 ** CFG_IDX_W; k++) begin
          write_reg(CFG_IDX_W'(k), 16'hFFFF);
        end
      end
      close_writes();
      if (p == 0) hold_off_pending = 1'b1;
      stop_at = sent_count + PHASE_ITEMS;
      while (sent_count < stop_at) begin
        if ($urandom_range(0, 3) != 0) begin
          run_roundabout_pass();
        end else begin
          send_coils(noise_row());
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
